[design/pga_pkg.sv]
// Shared types and constants for the pairwise gravity accelerator.
// Used by every module of the block; depends on nothing.
package pga_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int SQRT_STEPS  = 48;
   localparam int DIV_STEPS   = 32;

   // CSR indexes
   localparam logic CSR_GRAV_CONST = 1'b0;
   localparam logic CSR_SOFTENING  = 1'b1;

   localparam logic [31:0] GRAV_CONST_RESET = 32'd16777216;
   localparam logic [31:0] SOFTENING_RESET  = 32'd42950;

   typedef struct packed {
      logic signed [31:0] pos_a_x;
      logic signed [31:0] pos_a_y;
      logic signed [31:0] pos_a_z;
      logic [31:0]        mass_a;
      logic signed [31:0] pos_b_x;
      logic signed [31:0] pos_b_y;
      logic signed [31:0] pos_b_z;
      logic [31:0]        mass_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] accel_a_dx;
      logic signed [31:0] accel_a_dy;
      logic signed [31:0] accel_a_dz;
      logic signed [31:0] accel_b_dx;
      logic signed [31:0] accel_b_dy;
      logic signed [31:0] accel_b_dz;
   } rsp_type;

   // One classified pair: Q32.32 distance squared, G*m*|r| per output
   // component (A x,y,z then B x,y,z) and the sign of each component.
   typedef struct packed {
      logic [63:0]      d2;
      logic [5:0][96:0] kr;
      logic [5:0]       neg;
   } work_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              empty;
   } queue_status_type;

endpackage

[design/pga_front.sv]
// Front end: takes request words, forms r, |r|^2 + softening and G*m*|r|.
// Depends on pga_pkg. Admits a word only if the queue has room for it.
module pga_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pga_pkg::req_type              req_data,
   input  logic [31:0]                   grav_const,
   input  logic [31:0]                   softening,
   input  logic [pga_pkg::QCNT_W-1:0]    q_count,
   output logic                          push,
   output pga_pkg::work_type             push_data,
   output logic [1:0]                    inflight
);

   logic        accept;
   logic        v1_ff, v2_ff, v3_ff;
   logic [32:0] r_in [3];
   logic [32:0] r1_ff [3];
   logic [63:0] ka1_ff, kb1_ff;
   logic [32:0] rmag [3];
   logic [64:0] sq_in [3];
   logic [64:0] sq2_ff [3];
   logic [64:0] pp_in [6][2];
   logic [64:0] pp2_ff [6][2];
   logic [5:0]  neg_in;
   logic [5:0]  neg2_ff;
   logic [66:0] d2_sum;
   logic [63:0] d2_in;
   logic [5:0][96:0] kr_in;
   pga_pkg::work_type work_ff;

   assign inflight  = {1'b0, v1_ff} + {1'b0, v2_ff} + {1'b0, v3_ff};
   assign req_ready = (q_count + pga_pkg::QCNT_W'(inflight))
                      < pga_pkg::QCNT_W'(pga_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   // stage 1: differences (exact, 33 bits) and k = G*m
   always_comb begin
      r_in[0] = {req_data.pos_b_x[31], req_data.pos_b_x} - {req_data.pos_a_x[31], req_data.pos_a_x};
      r_in[1] = {req_data.pos_b_y[31], req_data.pos_b_y} - {req_data.pos_a_y[31], req_data.pos_a_y};
      r_in[2] = {req_data.pos_b_z[31], req_data.pos_b_z} - {req_data.pos_a_z[31], req_data.pos_a_z};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      r1_ff  <= r_in;
      kb1_ff <= grav_const * req_data.mass_b;
      ka1_ff <= grav_const * req_data.mass_a;
   end

   // stage 2: squares and k*|r| partial products (k split in halves)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rmag[i]  = r1_ff[i][32] ? 33'(-r1_ff[i]) : r1_ff[i];
         sq_in[i] = rmag[i] * rmag[i];
         pp_in[i][0]     = kb1_ff[31:0]  * rmag[i];
         pp_in[i][1]     = kb1_ff[63:32] * rmag[i];
         pp_in[3 + i][0] = ka1_ff[31:0]  * rmag[i];
         pp_in[3 + i][1] = ka1_ff[63:32] * rmag[i];
         neg_in[i]     = r1_ff[i][32];
         neg_in[3 + i] = !r1_ff[i][32] && (r1_ff[i] != '0);
      end
   end

   always_ff @(posedge clock) begin
      sq2_ff  <= sq_in;
      pp2_ff  <= pp_in;
      neg2_ff <= neg_in;
   end

   // stage 3: saturating d2 and full k*|r|
   always_comb begin
      d2_sum = 67'(sq2_ff[0]) + 67'(sq2_ff[1]) + 67'(sq2_ff[2]) + 67'(softening);
      d2_in  = (d2_sum[66:64] != 3'b000) ? '1 : d2_sum[63:0];
      for (int c = 0; c < 6; c++) begin
         kr_in[c] = {pp2_ff[c][1], 32'b0} + 97'(pp2_ff[c][0]);
      end
   end

   always_ff @(posedge clock) begin
      work_ff.d2  <= d2_in;
      work_ff.kr  <= kr_in;
      work_ff.neg <= neg2_ff;
   end

   assign push      = v3_ff;
   assign push_data = work_ff;

endmodule

[design/pga_queue.sv]
// Short queue between front end and back end.
// Depends on pga_pkg.
module pga_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pga_pkg::work_type          push_data,
   input  logic                       pop,
   output pga_pkg::work_type          head,
   output pga_pkg::queue_status_type  status
);

   pga_pkg::work_type entry_ff [pga_pkg::QUEUE_DEPTH];
   logic [pga_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [pga_pkg::QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);

endmodule

[design/pga_back.sv]
// Back end: pipelined square root, denominator, restoring divide and
// saturation, ending in the result register. Depends on pga_pkg.
module pga_back (
   input  logic                       clock,
   input  logic                       reset,
   input  pga_pkg::queue_status_type  q_status,
   input  pga_pkg::work_type          head,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pga_pkg::rsp_type           rsp_data
);

   localparam int SN = pga_pkg::SQRT_STEPS;
   localparam int DN = pga_pkg::DIV_STEPS;

   logic adv;

   logic              sq_v_ff    [SN+1];
   logic [47:0]       sq_root_ff [SN+1];
   logic [49:0]       sq_rem_ff  [SN+1];
   pga_pkg::work_type sq_work_ff [SN+1];

   logic             m_v_ff;
   logic [63:0]      m_pp0_ff, m_pp2_ff;
   logic [47:0]      m_pp1_ff, m_pp3_ff;
   logic [5:0][96:0] m_kr_ff;
   logic [5:0]       m_neg_ff;

   logic             n_v_ff;
   logic [111:0]     n_den_ff;
   logic [5:0][96:0] n_kr_ff;
   logic [5:0]       n_neg_ff;

   logic              dv_v_ff    [DN+1];
   logic [111:0]      dv_den_ff  [DN+1];
   logic [5:0][111:0] dv_rem_ff  [DN+1];
   logic [5:0][31:0]  dv_low_ff  [DN+1];
   logic [5:0][31:0]  dv_q_ff    [DN+1];
   logic [5:0]        dv_ovf_ff  [DN+1];
   logic [5:0]        dv_neg_ff  [DN+1];
   logic              dv_dz_ff   [DN+1];

   logic [5:0]        ovf_in;
   logic [5:0][111:0] rem0_in;
   logic [5:0][31:0]  low0_in;
   logic [31:0]       res [6];
   logic              rsp_valid_ff;
   pga_pkg::rsp_type  rsp_data_ff;

   // whole back end moves together when the result register can take a word
   assign adv = !rsp_valid_ff || rsp_ready;
   assign pop = adv && !q_status.empty;

   always_ff @(posedge clock) begin
      if (reset) sq_v_ff[0] <= 1'b0;
      else if (adv) sq_v_ff[0] <= pop;
      if (adv) begin
         sq_work_ff[0] <= head;
         sq_root_ff[0] <= '0;
         sq_rem_ff[0]  <= '0;
      end
   end

   // digit-by-digit root of d2*2^32, two radicand bits per stage
   for (genvar j = 0; j < SN; j++) begin : g_sqrt
      logic [1:0]  pair;
      logic [51:0] tmp;
      logic [51:0] trial;
      logic        ge;

      if (j < 32) begin : g_src
         assign pair = sq_work_ff[j].d2[63 - 2*j -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      assign tmp   = {sq_rem_ff[j], pair};
      assign trial = {2'b00, sq_root_ff[j], 2'b01};
      assign ge    = (tmp >= trial);

      always_ff @(posedge clock) begin
         if (reset) sq_v_ff[j+1] <= 1'b0;
         else if (adv) sq_v_ff[j+1] <= sq_v_ff[j];
         if (adv) begin
            sq_work_ff[j+1] <= sq_work_ff[j];
            sq_root_ff[j+1] <= {sq_root_ff[j][46:0], ge};
            sq_rem_ff[j+1]  <= ge ? 50'(tmp - trial) : tmp[49:0];
         end
      end
   end

   // den = d2 * s, four partial products then one sum
   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
         n_v_ff <= 1'b0;
      end else if (adv) begin
         m_v_ff <= sq_v_ff[SN];
         n_v_ff <= m_v_ff;
      end
      if (adv) begin
         m_pp0_ff <= sq_work_ff[SN].d2[31:0]  * sq_root_ff[SN][31:0];
         m_pp1_ff <= sq_work_ff[SN].d2[31:0]  * sq_root_ff[SN][47:32];
         m_pp2_ff <= sq_work_ff[SN].d2[63:32] * sq_root_ff[SN][31:0];
         m_pp3_ff <= sq_work_ff[SN].d2[63:32] * sq_root_ff[SN][47:32];
         m_kr_ff  <= sq_work_ff[SN].kr;
         m_neg_ff <= sq_work_ff[SN].neg;
         n_den_ff <= 112'(m_pp0_ff) + {32'b0, m_pp1_ff, 32'b0}
                     + {16'b0, m_pp2_ff, 32'b0} + {m_pp3_ff, 64'b0};
         n_kr_ff  <= m_kr_ff;
         n_neg_ff <= m_neg_ff;
      end
   end

   // numerator is kr * 2^24; quotient >= 2^32 means saturate
   always_comb begin
      for (int c = 0; c < 6; c++) begin
         ovf_in[c]  = ({23'b0, n_kr_ff[c][96:8]} >= n_den_ff);
         rem0_in[c] = {23'b0, n_kr_ff[c][96:8]};
         low0_in[c] = {n_kr_ff[c][7:0], 24'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dv_v_ff[0] <= 1'b0;
      else if (adv) dv_v_ff[0] <= n_v_ff;
      if (adv) begin
         dv_den_ff[0] <= n_den_ff;
         dv_rem_ff[0] <= rem0_in;
         dv_low_ff[0] <= low0_in;
         dv_q_ff[0]   <= '0;
         dv_ovf_ff[0] <= ovf_in;
         dv_neg_ff[0] <= n_neg_ff;
         dv_dz_ff[0]  <= (n_den_ff == '0);
      end
   end

   // restoring divide, one quotient bit per stage for all six components
   for (genvar i = 0; i < DN; i++) begin : g_div
      logic [5:0][112:0] tmp;
      logic [5:0]        ge;
      logic [5:0][111:0] rem_nx;
      logic [5:0][31:0]  low_nx;
      logic [5:0][31:0]  q_nx;

      always_comb begin
         for (int c = 0; c < 6; c++) begin
            tmp[c]    = {dv_rem_ff[i][c], dv_low_ff[i][c][31]};
            ge[c]     = (tmp[c] >= {1'b0, dv_den_ff[i]});
            rem_nx[c] = ge[c] ? 112'(tmp[c] - {1'b0, dv_den_ff[i]}) : tmp[c][111:0];
            low_nx[c] = {dv_low_ff[i][c][30:0], 1'b0};
            q_nx[c]   = {dv_q_ff[i][c][30:0], ge[c]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_v_ff[i+1] <= 1'b0;
         else if (adv) dv_v_ff[i+1] <= dv_v_ff[i];
         if (adv) begin
            dv_den_ff[i+1] <= dv_den_ff[i];
            dv_rem_ff[i+1] <= rem_nx;
            dv_low_ff[i+1] <= low_nx;
            dv_q_ff[i+1]   <= q_nx;
            dv_ovf_ff[i+1] <= dv_ovf_ff[i];
            dv_neg_ff[i+1] <= dv_neg_ff[i];
            dv_dz_ff[i+1]  <= dv_dz_ff[i];
         end
      end
   end

   // clamp, apply sign; coincident particles with no softening give zero
   always_comb begin
      logic [31:0] limit;
      logic [31:0] mag;
      for (int c = 0; c < 6; c++) begin
         limit  = dv_neg_ff[DN][c] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         mag    = (dv_ovf_ff[DN][c] || dv_q_ff[DN][c] > limit) ? limit : dv_q_ff[DN][c];
         res[c] = dv_dz_ff[DN] ? 32'd0 : (dv_neg_ff[DN][c] ? 32'd0 - mag : mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= dv_v_ff[DN];
      if (adv) begin
         rsp_data_ff.accel_a_dx <= res[0];
         rsp_data_ff.accel_a_dy <= res[1];
         rsp_data_ff.accel_a_dz <= res[2];
         rsp_data_ff.accel_b_dx <= res[3];
         rsp_data_ff.accel_b_dy <= res[4];
         rsp_data_ff.accel_b_dz <= res[5];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[design/pairwise_gravity_accel.sv]
// Throughput: one word per cycle while rsp_ready is high; the 48-stage
//   root and the 32-stage divide are fully pipelined, the 8-entry queue
//   sets the admit credit.
// Reset: synchronous, active high; clears all valids, the queue and loads
//   the CSRs with G = 1.0 and softening = 42950. No clearing pass.
module pairwise_gravity_accel (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  pga_pkg::req_type  req_data,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pga_pkg::rsp_type  rsp_data,
   // CSR write port
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);

   logic [31:0] grav_const_ff;
   logic [31:0] softening_ff;

   logic                       q_push;
   logic                       q_pop;
   pga_pkg::work_type          q_push_data;
   pga_pkg::work_type          q_head;
   pga_pkg::queue_status_type  q_status;
   logic [1:0]                 front_inflight;

   // CSRs, to be written only while the block is idle; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         grav_const_ff <= pga_pkg::GRAV_CONST_RESET;
         softening_ff  <= pga_pkg::SOFTENING_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            pga_pkg::CSR_GRAV_CONST: grav_const_ff <= csr_wdata;
            pga_pkg::CSR_SOFTENING:  softening_ff  <= csr_wdata;
            default:                 grav_const_ff <= grav_const_ff;
         endcase
      end
   end

   // front: 3 stages, always advances; admits a word only against
   // free queue space counting words still in its own stages
   pga_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .grav_const (grav_const_ff),
      .softening  (softening_ff),
      .q_count    (q_status.count),
      .push       (q_push),
      .push_data  (q_push_data),
      .inflight   (front_inflight)
   );

   pga_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   // back: stalls as one unit behind the result register
   pga_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // credit scheme never lets the queue plus front stages exceed the queue
   a_credit: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, q_status.count} + 5'(front_inflight)) <= 5'(pga_pkg::QUEUE_DEPTH))
      else $error("queue credit overrun");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_status.count != 4'(pga_pkg::QUEUE_DEPTH)) || q_pop)
      else $error("push into full queue");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

[verif/tb_top.sv]
// Self-checking bench for pairwise_gravity_accel: directed table plus random pairs.
// Depends on design/pga_pkg.sv and design/pairwise_gravity_accel.sv.
module tb_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_WAIT   = 200;   // well past the depth of the pipe

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   pga_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   pga_pkg::rsp_type rsp_data;
   logic             csr_write_en;
   logic             csr_index;
   logic [31:0]      csr_wdata;

   pairwise_gravity_accel dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // bench copy of the CSRs
   logic [31:0] model_g;
   logic [31:0] model_soft;

   pga_pkg::rsp_type accel_q[$];     // expected increments, oldest first
   int      errors;
   int      cycles;
   bit      calm;           // no idling on the req side while set

   typedef struct {
      logic [31:0]      g;
      logic [31:0]      softening;
      pga_pkg::req_type data;
      bit               typed;
      pga_pkg::rsp_type result;
   } row_type;
   row_type rows[$];

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   // One output component: floor(k*|r|*2^24 / den), saturated, signed.
   function automatic logic [31:0] accel_part(logic [63:0] k, logic [32:0] mag,
                                              bit neg, logic [127:0] den);
      logic [127:0] num;
      logic [127:0] quo;
      logic [31:0]  lim;
      logic [31:0]  m;
      if (den == 0 || mag == 0 || k == 0) return 32'd0;
      num = {64'd0, k};
      num = (num * {95'd0, mag}) << 24;
      quo = num / den;
      lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      m   = (quo > {96'd0, lim}) ? lim : quo[31:0];
      return neg ? (32'd0 - m) : m;
   endfunction

   function automatic pga_pkg::rsp_type pair_accel(pga_pkg::req_type p);
      logic signed [32:0] r[3];
      logic [32:0]  mag[3];
      logic [31:0]  pa[3];
      logic [31:0]  pb[3];
      logic [67:0]  sum;
      logic [63:0]  d2;
      logic [95:0]  x;
      logic [95:0]  cw;
      logic [47:0]  s;
      logic [47:0]  cand;
      logic [127:0] den;
      logic [63:0]  ka;
      logic [63:0]  kb;
      pga_pkg::rsp_type o;
      pa[0] = p.pos_a_x; pa[1] = p.pos_a_y; pa[2] = p.pos_a_z;
      pb[0] = p.pos_b_x; pb[1] = p.pos_b_y; pb[2] = p.pos_b_z;
      sum = 68'd0;
      for (int i = 0; i < 3; i++) begin
         r[i]   = $signed({pb[i][31], pb[i]}) - $signed({pa[i][31], pa[i]});
         mag[i] = r[i][32] ? (33'd0 - r[i]) : r[i];
         sum    = sum + {35'd0, mag[i]} * {35'd0, mag[i]};
      end
      sum = sum + {36'd0, model_soft};
      d2  = (sum > 68'hFFFF_FFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
      // bitwise floor(sqrt(d2 * 2^32))
      x = {d2, 32'd0};
      s = 48'd0;
      for (int b = 47; b >= 0; b--) begin
         cand = s | (48'd1 << b);
         cw   = {48'd0, cand};
         if (cw * cw <= x) s = cand;
      end
      den = {64'd0, d2};
      den = den * {80'd0, s};
      kb  = {32'd0, model_g} * {32'd0, p.mass_b};
      ka  = {32'd0, model_g} * {32'd0, p.mass_a};
      o.accel_a_dx = accel_part(kb, mag[0], r[0] < 0, den);
      o.accel_a_dy = accel_part(kb, mag[1], r[1] < 0, den);
      o.accel_a_dz = accel_part(kb, mag[2], r[2] < 0, den);
      o.accel_b_dx = accel_part(ka, mag[0], r[0] > 0, den);
      o.accel_b_dy = accel_part(ka, mag[1], r[1] > 0, den);
      o.accel_b_dz = accel_part(ka, mag[2], r[2] > 0, den);
      return o;
   endfunction

   // ---------------- result side ----------------
   // ready toggles in held runs: mostly short, a few long stalls, some solid stretches
   int ready_hold;
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2:    begin rsp_ready <= 1'b0; ready_hold <= $urandom_range(0, 3); end
            3:          begin rsp_ready <= 1'b0; ready_hold <= $urandom_range(10, 40); end
            4:          begin rsp_ready <= 1'b1; ready_hold <= $urandom_range(30, 120); end
            default:    begin rsp_ready <= 1'b1; ready_hold <= $urandom_range(0, 5); end
         endcase
      end
   end

   // checker: every accepted word against the oldest expectation
   always @(posedge clock) begin
      logic [191:0] e;
      logic [191:0] a;
      string names[6];
      names = '{"accel_a_dx", "accel_a_dy", "accel_a_dz",
                "accel_b_dx", "accel_b_dy", "accel_b_dz"};
      if (!reset && rsp_valid && rsp_ready) begin
         if (accel_q.size() == 0) begin
            $display("%0t: rsp word with nothing expected, actual %h", $time, rsp_data);
            errors++;
         end else begin
            e = accel_q.pop_front();
            a = rsp_data;
            for (int i = 0; i < 6; i++)
               if (e[191 - 32*i -: 32] !== a[191 - 32*i -: 32]) begin
                  $display("%0t: %s expected %h actual %h", $time, names[i],
                           e[191 - 32*i -: 32], a[191 - 32*i -: 32]);
                  errors++;
               end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------- request side ----------------
   function automatic int req_gap();
      int pick;
      if (calm) return 0;
      pick = $urandom_range(0, 19);
      if (pick < 11) return 0;
      if (pick < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Present one word, hold it until taken, then queue its expectation.
   // Ends on the falling edge after acceptance so back-to-back words
   // just change the payload with valid left high.
   task automatic send_pair(pga_pkg::req_type d, bit typed, pga_pkg::rsp_type typed_result);
      int gap;
      gap = req_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      accel_q.push_back(typed ? typed_result : pair_accel(d));
      @(negedge clock);
   endtask

   // Let the pipe empty before touching CSRs.
   task automatic drain();
      req_valid <= 1'b0;
      while (accel_q.size() != 0) @(negedge clock);
      repeat (TAIL_WAIT) @(negedge clock);
   endtask

   // one write strobe, then the enable is held low before returning so strobes never merge
   task automatic csr_write(logic idx, logic [31:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
      if (idx == pga_pkg::CSR_GRAV_CONST) model_g = val;
      else model_soft = val;
   endtask

   task automatic set_config(logic [31:0] g, logic [31:0] soft_val);
      if (g != model_g || soft_val != model_soft) begin
         drain();
         csr_write(pga_pkg::CSR_GRAV_CONST, g);
         csr_write(pga_pkg::CSR_SOFTENING, soft_val);
      end
   endtask

   function automatic pga_pkg::req_type make_req(logic [31:0] ax, logic [31:0] ay,
                                                 logic [31:0] az, logic [31:0] ma,
                                                 logic [31:0] bx, logic [31:0] by,
                                                 logic [31:0] bz, logic [31:0] mb);
      pga_pkg::req_type q;
      q.pos_a_x = ax; q.pos_a_y = ay; q.pos_a_z = az; q.mass_a = ma;
      q.pos_b_x = bx; q.pos_b_y = by; q.pos_b_z = bz; q.mass_b = mb;
      return q;
   endfunction

   task automatic add_row(logic [31:0] g, logic [31:0] soft_val, pga_pkg::req_type d,
                          bit typed, pga_pkg::rsp_type res);
      row_type w;
      w.g = g; w.softening = soft_val; w.data = d; w.typed = typed; w.result = res;
      rows.push_back(w);
   endtask

   // random position offset, mostly small
   function automatic logic [31:0] near_offset();
      logic [31:0] v;
      v = $urandom >> $urandom_range(4, 31);
      return $urandom_range(0, 1) ? (32'd0 - v) : v;
   endfunction

   function automatic logic [31:0] rand_mass();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom >> $urandom_range(8, 24);
         default: return $urandom;
      endcase
   endfunction

   function automatic pga_pkg::req_type rand_pair();
      pga_pkg::req_type q;
      logic [31:0] pa[3];
      logic [31:0] pb[3];
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         pa[i] = $urandom;
         case (mode)
            0, 1, 2, 3: pb[i] = $urandom;
            8:          pb[i] = pa[i];                               // coincident
            9:          pb[i] = (i == 0) ? pa[i] + near_offset() : pa[i];
            default:    pb[i] = pa[i] + near_offset();               // close pair
         endcase
      end
      return make_req(pa[0], pa[1], pa[2], rand_mass(),
                      pb[0], pb[1], pb[2], rand_mass());
   endfunction

   // ---------------- main sequence ----------------
   initial begin
      pga_pkg::rsp_type zero_res;
      pga_pkg::rsp_type sat_ab;
      pga_pkg::rsp_type sat_ba;
      logic [31:0] g_pick;
      logic [31:0] s_pick;
      logic [31:0] one;
      logic [31:0] mn;
      logic [31:0] mx;
      logic [31:0] ffff;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_ready    = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = pga_pkg::CSR_GRAV_CONST;
      csr_wdata    = 32'd0;
      ready_hold   = 0;
      errors       = 0;
      cycles       = 0;
      calm         = 1'b0;
      model_g      = pga_pkg::GRAV_CONST_RESET;
      model_soft   = pga_pkg::SOFTENING_RESET;

      zero_res = '0;
      // one LSB apart, huge mass: quotient far past full scale
      sat_ab = '{32'h7FFF_FFFF, 32'd0, 32'd0, 32'h8000_0000, 32'd0, 32'd0};
      sat_ba = '{32'h8000_0000, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0};
      one  = 32'h0001_0000;
      mn   = 32'h8000_0000;
      mx   = 32'h7FFF_FFFF;
      ffff = 32'hFFFF_FFFF;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table, reset CSR values first
      add_row(pga_pkg::GRAV_CONST_RESET, pga_pkg::SOFTENING_RESET,
              make_req(0, 0, 0, one, 0, 0, 0, one), 1, zero_res);        // same spot
      add_row(pga_pkg::GRAV_CONST_RESET, pga_pkg::SOFTENING_RESET,
              make_req(0, 0, 0, 0, one, one, one, 0), 1, zero_res);      // massless
      add_row(pga_pkg::GRAV_CONST_RESET, pga_pkg::SOFTENING_RESET,
              make_req(0, 0, 0, ffff, 1, 0, 0, ffff), 1, sat_ab);        // overflow +
      add_row(pga_pkg::GRAV_CONST_RESET, pga_pkg::SOFTENING_RESET,
              make_req(1, 0, 0, ffff, 0, 0, 0, ffff), 1, sat_ba);        // overflow -
      add_row(pga_pkg::GRAV_CONST_RESET, pga_pkg::SOFTENING_RESET,
              make_req(0, 0, 0, one, one, 0, 0, one), 0, zero_res);      // unit distance
      add_row(pga_pkg::GRAV_CONST_RESET, pga_pkg::SOFTENING_RESET,
              make_req(mn, mn, mn, ffff, mx, mx, mx, ffff), 0, zero_res);// d2 saturates
      add_row(pga_pkg::GRAV_CONST_RESET, pga_pkg::SOFTENING_RESET,
              make_req(mx, mx, mx, ffff, mn, mn, mn, ffff), 0, zero_res);
      add_row(pga_pkg::GRAV_CONST_RESET, pga_pkg::SOFTENING_RESET,
              make_req(0, 0, 0, 1, mx, 0, 0, 1), 0, zero_res);           // tiny result
      add_row(pga_pkg::GRAV_CONST_RESET, pga_pkg::SOFTENING_RESET,
              make_req(mx, 0, mn, one, mn, one, mx, one), 0, zero_res);
      // G = 0
      add_row(32'd0, pga_pkg::SOFTENING_RESET,
              make_req(0, 0, 0, ffff, 1, 1, 1, ffff), 1, zero_res);
      // both registers at full scale
      add_row(ffff, ffff, make_req(0, 0, 0, ffff, 0, 0, 0, ffff), 1, zero_res);
      add_row(ffff, ffff, make_req(0, 0, 0, ffff, one, one, one, ffff), 0, zero_res);
      add_row(ffff, ffff, make_req(mn, mn, mn, ffff, mx, mx, mx, ffff), 0, zero_res);
      add_row(ffff, ffff, make_req(0, 0, 0, 1, 1, 0, 0, 1), 0, zero_res);
      // no softening: coincident pair has a zero denominator
      add_row(pga_pkg::GRAV_CONST_RESET, 32'd0,
              make_req(one, one, one, ffff, one, one, one, ffff), 1, zero_res);
      add_row(pga_pkg::GRAV_CONST_RESET, 32'd0,
              make_req(0, 0, 0, one, 0, 0, 1, one), 0, zero_res);
      add_row(pga_pkg::GRAV_CONST_RESET, 32'd0,
              make_req(mn, 0, 0, ffff, mx, 0, 0, ffff), 0, zero_res);
      add_row(pga_pkg::GRAV_CONST_RESET, 32'd0,
              make_req(0, 0, 0, one, 32'hFFFF_0000, 0, 0, one), 0, zero_res);

      foreach (rows[i]) begin
         set_config(rows[i].g, rows[i].softening);
         send_pair(rows[i].data, rows[i].typed, rows[i].result);
      end

      // random part: ten CSR settings, about 65 pairs each
      for (int ph = 0; ph < 10; ph++) begin
         case (ph % 5)
            0: begin
               g_pick = pga_pkg::GRAV_CONST_RESET;
               s_pick = pga_pkg::SOFTENING_RESET;
            end
            1: begin g_pick = $urandom;         s_pick = $urandom >> $urandom_range(0, 31); end
            2: begin g_pick = ffff;             s_pick = 32'd0; end
            3: begin g_pick = $urandom >> 6;    s_pick = ffff; end
            default: begin g_pick = $urandom;   s_pick = $urandom; end
         endcase
         set_config(g_pick, s_pick);
         for (int n = 0; n < 65; n++) begin
            if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
            send_pair(rand_pair(), 0, zero_res);
         end
         calm = 1'b0;
      end

      drain();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
